FILE: rtl/ffa_pkg.sv
// Shared types and constants of the first-fit allocator.
// Used by ffa_ctrl, ffa_dp and the top level; depends on nothing.
`default_nettype none

package ffa_pkg;

    localparam int ADDR_W = 20;
    localparam int LEN_W  = 21;
    localparam int KIND_W = 2;
    localparam int STAT_W = 3;

    localparam logic [LEN_W-1:0] POOL_BYTES = LEN_W'(1048576);

    localparam int DEF_FREE_ENTRIES = 64;
    localparam int DEF_USED_ENTRIES = 64;

    localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REALLOC = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
    localparam logic [STAT_W-1:0] ST_NOFIT   = 3'd1;
    localparam logic [STAT_W-1:0] ST_BADADDR = 3'd2;
    localparam logic [STAT_W-1:0] ST_ZERO    = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL    = 3'd4;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [ADDR_W-1:0] start;
    } entry_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_INIT,
        OP_LOAD,
        OP_SCAN_U,
        OP_SCAN_F,
        OP_SCAN_N,
        OP_WR_FA,
        OP_WR_UI,
        OP_WR_UR,
        OP_WR_FM,
        OP_WR_FN,
        OP_RESULT
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [STAT_W-1:0] code;
    } cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              size_zero;
        logic              used_full;
        logic              free_full;
        logic              scan_done;
        logic              u_found;
        logic              f_found;
        logic              merge_p;
        logic              merge_n;
        logic              out_busy;
    } sts_t;

endpackage

`default_nettype wire

FILE: rtl/first_fit_allocator_coalescing.sv
// Top level of the first-fit byte-pool allocator with free-extent coalescing.
// Depends on ffa_pkg, ffa_ctrl, ffa_dp (and ffa_ram below it).
//
//  Channel | Dir | Beat contents
//  --------+-----+-------------------------------------------------------------
//  s_axis  | in  | tuser: kind; tdata: req_size, block_addr
//  m_axis  | out | tdata: result_addr, copy_length, status
//
// A request walks the used table once and the free table at most twice, entry
// by entry up to each table's high-water mark, through its one read port.
// After reset the initial free extent is written with s_tready low.
// A new request is taken while a result waits; the next result waits for m_tready.
`default_nettype none

module first_fit_allocator_coalescing #(
    parameter int FREE_ENTRIES = ffa_pkg::DEF_FREE_ENTRIES,
    parameter int USED_ENTRIES = ffa_pkg::DEF_USED_ENTRIES
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // req_size[20:0], block_addr[40:21], zero
    input  wire logic [1:0]  s_tuser,   // kind[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [47:0] m_tdata    // result_addr[19:0], copy_length[40:20],
                                        // status[43:41], zero
);

    import ffa_pkg::*;

    cmd_t              cmd;
    sts_t              sts;
    logic [ADDR_W-1:0] res_addr;
    logic [LEN_W-1:0]  res_copy;
    logic [STAT_W-1:0] res_stat;

    ffa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ffa_dp #(
        .FREE_ENTRIES (FREE_ENTRIES),
        .USED_ENTRIES (USED_ENTRIES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .kind        (s_tuser),
        .req_size    (s_tdata[20:0]),
        .block_addr  (s_tdata[40:21]),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .result_addr (res_addr),
        .copy_length (res_copy),
        .status      (res_stat)
    );

    assign m_tdata = {4'b0, res_stat, res_copy, res_addr};

endmodule

`default_nettype wire

FILE: rtl/ffa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/ffa_ctrl.sv
// Request sequencer of the first-fit allocator: scans, checks and commit steps.
// Depends on ffa_pkg; drives ffa_dp through cmd_t and reads sts_t.
`default_nettype none

module ffa_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire ffa_pkg::sts_t sts,
    output ffa_pkg::cmd_t      cmd
);

    import ffa_pkg::*;

    typedef enum logic [11:0] {
        S_INIT   = 12'b0000_0000_0001,
        S_IDLE   = 12'b0000_0000_0010,
        S_CHECK  = 12'b0000_0000_0100,
        S_SCAN_U = 12'b0000_0000_1000,
        S_SCAN_F = 12'b0000_0001_0000,
        S_SCAN_N = 12'b0000_0010_0000,
        S_WR_FA  = 12'b0000_0100_0000,
        S_WR_UI  = 12'b0000_1000_0000,
        S_WR_UR  = 12'b0001_0000_0000,
        S_WR_FM  = 12'b0010_0000_0000,
        S_WR_FN  = 12'b0100_0000_0000,
        S_RES    = 12'b1000_0000_0000
    } state_t;

    state_t            state_reg, state_next;
    logic [STAT_W-1:0] code_reg, code_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            code_reg  <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        code_next  = code_reg;
        in_ready   = 1'b0;
        cmd.op     = OP_NOP;
        cmd.code   = code_reg;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.op     = OP_INIT;
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = S_RES;
                code_next  = ST_OK;
                unique case (sts.kind)
                    KIND_ALLOC:
                    begin
                        if (sts.size_zero)
                        begin
                            code_next = ST_ZERO;
                        end
                        else if (sts.used_full)
                        begin
                            code_next = ST_FULL;
                        end
                        else
                        begin
                            state_next = S_SCAN_U;
                        end
                    end
                    KIND_FREE, KIND_REALLOC:
                    begin
                        state_next = S_SCAN_U;
                    end
                    default:
                    begin
                        state_next = S_RES;
                    end
                endcase
            end
            S_SCAN_U:
            begin
                cmd.op = OP_SCAN_U;
                if (sts.scan_done)
                begin
                    state_next = S_RES;
                    if (sts.kind == KIND_ALLOC)
                    begin
                        state_next = S_SCAN_F;
                    end
                    else if (!sts.u_found)
                    begin
                        code_next = ST_BADADDR;
                    end
                    else if (sts.kind == KIND_FREE)
                    begin
                        state_next = S_SCAN_N;
                    end
                    else if (sts.size_zero)
                    begin
                        code_next = ST_ZERO;
                    end
                    else if (sts.used_full)
                    begin
                        code_next = ST_FULL;
                    end
                    else
                    begin
                        state_next = S_SCAN_F;
                    end
                end
            end
            S_SCAN_F:
            begin
                cmd.op = OP_SCAN_F;
                if (sts.scan_done)
                begin
                    if (!sts.f_found)
                    begin
                        code_next  = ST_NOFIT;
                        state_next = S_RES;
                    end
                    else if (sts.kind == KIND_ALLOC)
                    begin
                        state_next = S_WR_FA;
                    end
                    else
                    begin
                        state_next = S_SCAN_N;
                    end
                end
            end
            S_SCAN_N:
            begin
                cmd.op = OP_SCAN_N;
                if (sts.scan_done)
                begin
                    if (!sts.merge_p && !sts.merge_n && sts.free_full)
                    begin
                        code_next  = ST_FULL;
                        state_next = S_RES;
                    end
                    else if (sts.kind == KIND_REALLOC)
                    begin
                        state_next = S_WR_FA;
                    end
                    else
                    begin
                        state_next = S_WR_UR;
                    end
                end
            end
            S_WR_FA:
            begin
                cmd.op     = OP_WR_FA;
                state_next = S_WR_UI;
            end
            S_WR_UI:
            begin
                cmd.op = OP_WR_UI;
                if (sts.kind == KIND_REALLOC)
                begin
                    state_next = S_WR_UR;
                end
                else
                begin
                    code_next  = ST_OK;
                    state_next = S_RES;
                end
            end
            S_WR_UR:
            begin
                cmd.op     = OP_WR_UR;
                state_next = S_WR_FM;
            end
            S_WR_FM:
            begin
                cmd.op = OP_WR_FM;
                if (sts.merge_p && sts.merge_n)
                begin
                    state_next = S_WR_FN;
                end
                else
                begin
                    code_next  = ST_OK;
                    state_next = S_RES;
                end
            end
            S_WR_FN:
            begin
                cmd.op     = OP_WR_FN;
                code_next  = ST_OK;
                state_next = S_RES;
            end
            S_RES:
            begin
                if (!sts.out_busy)
                begin
                    cmd.op     = OP_RESULT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/ffa_dp.sv
// Datapath of the first-fit allocator: extent tables, scan unit, counts, result.
// Depends on ffa_pkg and ffa_ram; sequenced by ffa_ctrl through cmd_t.
`default_nettype none

module ffa_dp #(
    parameter int FREE_ENTRIES = ffa_pkg::DEF_FREE_ENTRIES,
    parameter int USED_ENTRIES = ffa_pkg::DEF_USED_ENTRIES
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire ffa_pkg::cmd_t                cmd,
    output ffa_pkg::sts_t                     sts,
    input  wire logic [ffa_pkg::KIND_W-1:0]   kind,
    input  wire logic [ffa_pkg::LEN_W-1:0]    req_size,
    input  wire logic [ffa_pkg::ADDR_W-1:0]   block_addr,
    input  wire logic                         out_ready,
    output logic                              out_valid,
    output logic      [ffa_pkg::ADDR_W-1:0]   result_addr,
    output logic      [ffa_pkg::LEN_W-1:0]    copy_length,
    output logic      [ffa_pkg::STAT_W-1:0]   status
);

    import ffa_pkg::*;

    localparam int FI_W = $clog2(FREE_ENTRIES);
    localparam int UI_W = $clog2(USED_ENTRIES);
    localparam int FC_W = $clog2(FREE_ENTRIES + 1);
    localparam int UC_W = $clog2(USED_ENTRIES + 1);
    localparam int SC_W = (FC_W > UC_W) ? FC_W : UC_W;
    localparam int EW   = $bits(entry_t);

    // request
    logic [KIND_W-1:0] kind_reg;
    logic [LEN_W-1:0]  size_reg;
    logic [ADDR_W-1:0] baddr_reg;

    // table bookkeeping
    logic [FC_W-1:0] fc_reg, fc_next, hwf_reg, hwf_next;
    logic [UC_W-1:0] uc_reg, uc_next, hwu_reg, hwu_next;

    // scan unit
    logic [SC_W-1:0] cnt_reg, idx_reg, limit;
    logic            pend_reg, scan_act, issue, done;

    // scan results
    logic            u_found_reg, uh_found_reg;
    logic [UI_W-1:0] u_idx_reg, uh_idx_reg;
    logic [LEN_W-1:0] u_len_reg;
    logic            f_found_reg;
    logic [FI_W-1:0] f_idx_reg;
    logic [ADDR_W-1:0] f_start_reg, f_nstart_reg;
    logic [LEN_W-1:0]  f_len_reg, f_nlen_reg, f_end_reg;
    logic            p_found_reg, n_found_reg, h_found_reg;
    logic [FI_W-1:0] p_idx_reg, n_idx_reg, h_idx_reg;
    logic [ADDR_W-1:0] p_start_reg;
    logic [LEN_W-1:0]  p_len_reg, n_len_reg;

    // result
    logic              ov_reg;
    logic [ADDR_W-1:0] res_addr_reg;
    logic [LEN_W-1:0]  res_copy_reg;
    logic [STAT_W-1:0] res_stat_reg;

    // RAM ports
    entry_t          f_rd, u_rd, f_wd, u_wd;
    logic            f_we, u_we, f_re, u_re;
    logic [FI_W-1:0] f_wa;
    logic [UI_W-1:0] u_wa;
    logic [EW-1:0]   f_rd_raw, u_rd_raw;

    // view of the free table with the pending alloc applied
    logic              is_f, f_exact, v_valid;
    logic [ADDR_W-1:0] v_start;
    logic [LEN_W-1:0]  v_len, v_end, r_end, blk_end;
    logic [FC_W-1:0]   fc_after;

    assign f_rd = entry_t'(f_rd_raw);
    assign u_rd = entry_t'(u_rd_raw);

    assign scan_act = (cmd.op == OP_SCAN_U) || (cmd.op == OP_SCAN_F) ||
                      (cmd.op == OP_SCAN_N);
    assign limit    = (cmd.op == OP_SCAN_U) ? SC_W'(hwu_reg) : SC_W'(hwf_reg);
    assign issue    = scan_act && (cnt_reg < limit);
    assign done     = scan_act && (cnt_reg == limit) && !pend_reg;
    assign f_re     = issue && (cmd.op != OP_SCAN_U);
    assign u_re     = issue && (cmd.op == OP_SCAN_U);

    assign f_exact  = (f_len_reg == size_reg);
    assign r_end    = LEN_W'({1'b0, f_rd.start}) + f_rd.len;
    assign blk_end  = LEN_W'({1'b0, baddr_reg}) + u_len_reg;
    assign is_f     = f_found_reg && (idx_reg[FI_W-1:0] == f_idx_reg);
    assign v_start  = is_f ? f_nstart_reg : f_rd.start;
    assign v_len    = is_f ? (f_exact ? '0 : f_nlen_reg) : f_rd.len;
    assign v_end    = is_f ? f_end_reg : r_end;
    assign v_valid  = (v_len != '0);
    assign fc_after = fc_reg - FC_W'(f_found_reg && f_exact);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            pend_reg <= 1'b0;
            fc_reg   <= '0;
            hwf_reg  <= '0;
            uc_reg   <= '0;
            hwu_reg  <= '0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            pend_reg <= issue;
            if (issue)
            begin
                cnt_reg <= cnt_reg + SC_W'(1);
            end
            else if (done)
            begin
                cnt_reg <= '0;
            end
            fc_reg  <= fc_next;
            hwf_reg <= hwf_next;
            uc_reg  <= uc_next;
            hwu_reg <= hwu_next;
            if (cmd.op == OP_RESULT)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        fc_next  = fc_reg;
        hwf_next = hwf_reg;
        uc_next  = uc_reg;
        hwu_next = hwu_reg;
        f_we     = 1'b0;
        u_we     = 1'b0;
        f_wa     = f_idx_reg;
        u_wa     = u_idx_reg;
        f_wd     = '{len: '0, start: '0};
        u_wd     = '{len: '0, start: '0};
        unique case (cmd.op)
            OP_INIT:
            begin
                f_we     = 1'b1;
                f_wa     = '0;
                f_wd     = '{len: POOL_BYTES, start: '0};
                fc_next  = FC_W'(1);
                hwf_next = FC_W'(1);
            end
            OP_WR_FA:
            begin
                f_we = 1'b1;
                f_wa = f_idx_reg;
                if (f_exact)
                begin
                    f_wd    = '{len: '0, start: f_start_reg};
                    fc_next = fc_reg - FC_W'(1);
                end
                else
                begin
                    f_wd = '{len: f_nlen_reg, start: f_nstart_reg};
                end
            end
            OP_WR_UI:
            begin
                u_we    = 1'b1;
                u_wd    = '{len: size_reg, start: f_start_reg};
                uc_next = uc_reg + UC_W'(1);
                if (uh_found_reg)
                begin
                    u_wa = uh_idx_reg;
                end
                else
                begin
                    u_wa     = hwu_reg[UI_W-1:0];
                    hwu_next = hwu_reg + UC_W'(1);
                end
            end
            OP_WR_UR:
            begin
                u_we    = 1'b1;
                u_wa    = u_idx_reg;
                u_wd    = '{len: '0, start: baddr_reg};
                uc_next = uc_reg - UC_W'(1);
            end
            OP_WR_FM:
            begin
                f_we = 1'b1;
                if (p_found_reg && n_found_reg)
                begin
                    f_wa = p_idx_reg;
                    f_wd = '{len: LEN_W'(p_len_reg + u_len_reg + n_len_reg),
                             start: p_start_reg};
                end
                else if (p_found_reg)
                begin
                    f_wa = p_idx_reg;
                    f_wd = '{len: LEN_W'(p_len_reg + u_len_reg), start: p_start_reg};
                end
                else if (n_found_reg)
                begin
                    f_wa = n_idx_reg;
                    f_wd = '{len: LEN_W'(u_len_reg + n_len_reg), start: baddr_reg};
                end
                else
                begin
                    f_wd    = '{len: u_len_reg, start: baddr_reg};
                    fc_next = fc_reg + FC_W'(1);
                    if (h_found_reg)
                    begin
                        f_wa = h_idx_reg;
                    end
                    else
                    begin
                        f_wa     = hwf_reg[FI_W-1:0];
                        hwf_next = hwf_reg + FC_W'(1);
                    end
                end
            end
            OP_WR_FN:
            begin
                f_we    = 1'b1;
                f_wa    = n_idx_reg;
                f_wd    = '{len: '0, start: baddr_reg};
                fc_next = fc_reg - FC_W'(1);
            end
            default:
            begin
                f_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            idx_reg <= cnt_reg;
        end
        if (cmd.op == OP_LOAD)
        begin
            kind_reg     <= kind;
            size_reg     <= req_size;
            baddr_reg    <= block_addr;
            u_found_reg  <= 1'b0;
            uh_found_reg <= 1'b0;
            f_found_reg  <= 1'b0;
            f_start_reg  <= '0;
            p_found_reg  <= 1'b0;
            n_found_reg  <= 1'b0;
            h_found_reg  <= 1'b0;
        end
        if (pend_reg && (cmd.op == OP_SCAN_U))
        begin
            if ((u_rd.len != '0) && (u_rd.start == baddr_reg) && !u_found_reg)
            begin
                u_found_reg <= 1'b1;
                u_idx_reg   <= idx_reg[UI_W-1:0];
                u_len_reg   <= u_rd.len;
            end
            if ((u_rd.len == '0) && !uh_found_reg)
            begin
                uh_found_reg <= 1'b1;
                uh_idx_reg   <= idx_reg[UI_W-1:0];
            end
        end
        if (pend_reg && (cmd.op == OP_SCAN_F))
        begin
            if ((f_rd.len != '0) && (f_rd.len >= size_reg) &&
                (!f_found_reg || (f_rd.start < f_start_reg)))
            begin
                f_found_reg  <= 1'b1;
                f_idx_reg    <= idx_reg[FI_W-1:0];
                f_start_reg  <= f_rd.start;
                f_len_reg    <= f_rd.len;
                f_end_reg    <= r_end;
                f_nstart_reg <= ADDR_W'(LEN_W'({1'b0, f_rd.start}) + size_reg);
                f_nlen_reg   <= f_rd.len - size_reg;
            end
        end
        if (pend_reg && (cmd.op == OP_SCAN_N))
        begin
            if (v_valid && (v_end == LEN_W'({1'b0, baddr_reg})))
            begin
                p_found_reg <= 1'b1;
                p_idx_reg   <= idx_reg[FI_W-1:0];
                p_start_reg <= v_start;
                p_len_reg   <= v_len;
            end
            if (v_valid && (LEN_W'({1'b0, v_start}) == blk_end))
            begin
                n_found_reg <= 1'b1;
                n_idx_reg   <= idx_reg[FI_W-1:0];
                n_len_reg   <= v_len;
            end
            if (!v_valid && !h_found_reg)
            begin
                h_found_reg <= 1'b1;
                h_idx_reg   <= idx_reg[FI_W-1:0];
            end
        end
        if (cmd.op == OP_RESULT)
        begin
            res_stat_reg <= cmd.code;
            res_addr_reg <= (cmd.code == ST_OK) ? f_start_reg : '0;
            if ((cmd.code == ST_OK) && (kind_reg == KIND_REALLOC))
            begin
                res_copy_reg <= (size_reg < u_len_reg) ? size_reg : u_len_reg;
            end
            else
            begin
                res_copy_reg <= '0;
            end
        end
    end

    ffa_ram #(
        .WIDTH (EW),
        .DEPTH (FREE_ENTRIES)
    ) u_free_ram (
        .clk   (clk),
        .we    (f_we),
        .waddr (f_wa),
        .wdata (f_wd),
        .re    (f_re),
        .raddr (cnt_reg[FI_W-1:0]),
        .rdata (f_rd_raw)
    );

    ffa_ram #(
        .WIDTH (EW),
        .DEPTH (USED_ENTRIES)
    ) u_used_ram (
        .clk   (clk),
        .we    (u_we),
        .waddr (u_wa),
        .wdata (u_wd),
        .re    (u_re),
        .raddr (cnt_reg[UI_W-1:0]),
        .rdata (u_rd_raw)
    );

    assign sts.kind      = kind_reg;
    assign sts.size_zero = (size_reg == '0);
    assign sts.used_full = (uc_reg >= UC_W'(USED_ENTRIES));
    assign sts.free_full = (fc_after >= FC_W'(FREE_ENTRIES));
    assign sts.scan_done = done;
    assign sts.u_found   = u_found_reg;
    assign sts.f_found   = f_found_reg;
    assign sts.merge_p   = p_found_reg;
    assign sts.merge_n   = n_found_reg;
    assign sts.out_busy  = ov_reg && !out_ready;

    assign out_valid   = ov_reg;
    assign result_addr = res_addr_reg;
    assign copy_length = res_copy_reg;
    assign status      = res_stat_reg;

endmodule

`default_nettype wire
